>>> rtl/ppp_pkg.sv
// shared types, widths and codes for the pinhole point projection block
// no dependencies; imported by every module of the block
package ppp_pkg;

    // fixed-point formats
    localparam int COORD_FRAC_BITS = 16;
    localparam int PIXEL_FRAC_BITS = 8;
    localparam int ROT_FRAC        = 14;

    // field widths
    localparam int COORD_W = 32;
    localparam int ROT_W   = 16;
    localparam int ROW_W   = 3 * ROT_W;
    localparam int PIX_W   = 24;
    localparam int FOC_W   = 24;
    localparam int PP_W    = 20;
    localparam int IMG_W   = 12;
    localparam int STAT_W  = 2;

    // internal widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + ROT_W;
    localparam int CAM_W  = PROD_W + 2;
    localparam int SCL_W  = CAM_W - ROT_FRAC;
    localparam int DEN_W  = SCL_W - 1;
    localparam int NUM_W  = SCL_W - 1 + FOC_W;
    localparam int REM_W  = DEN_W + 1;
    localparam int QUO_W  = NUM_W - COORD_FRAC_BITS;
    localparam int U_W    = QUO_W + 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = FOC_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIN_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_W  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_H  = 3'd4;

    // reset values
    localparam logic [FOC_W-1:0] FOCAL_RST  = 24'd128000;
    localparam logic [PP_W-1:0]  PRIN_X_RST = 20'd81920;
    localparam logic [PP_W-1:0]  PRIN_Y_RST = 20'd61440;

    // status codes
    localparam logic [STAT_W-1:0] STAT_SUCCESS = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BEHIND  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OOB     = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic signed [COORD_W-1:0] world_z;
        logic [ROW_W-1:0]          rot_row0;
        logic [ROW_W-1:0]          rot_row1;
        logic [ROW_W-1:0]          rot_row2;
        logic signed [COORD_W-1:0] cam_pos_x;
        logic signed [COORD_W-1:0] cam_pos_y;
        logic signed [COORD_W-1:0] cam_pos_z;
    } ppp_in_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_u;
        logic signed [PIX_W-1:0] pixel_v;
        logic [STAT_W-1:0]       proj_status;
    } ppp_out_t;

    // one divider lane: partial remainder and numerator/quotient shift word
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] nq;
    } ppp_lane_t;

    // payload travelling down the divider chain
    typedef struct packed {
        logic             behind;
        logic             neg_u;
        logic             neg_v;
        logic [DEN_W-1:0] den;
        ppp_lane_t        lane_u;
        ppp_lane_t        lane_v;
    } ppp_div_t;

endpackage

>>> rtl/pinhole_point_projection.sv
// top level: configuration registers, transform, divider chain, output stage
// depends on ppp_pkg, ppp_xform, ppp_div_step
//
// Projects one world point per transaction through a camera pose and returns
// pixel_u, pixel_v and proj_status. The block is fully pipelined: a new point
// is accepted every cycle while the result side does not stall, and each
// result passes four transform stages, 60 one-bit division stages and one
// output register; the restoring divider gives one quotient bit per stage.
// When the result side stalls, the whole pipeline holds, so s_ready follows
// m_ready whenever a result is waiting. Configuration must only be written
// while no transaction is in flight.
module pinhole_point_projection (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ppp_pkg::ppp_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ppp_pkg::ppp_out_t              m_data,
    input  logic                           cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ppp_pkg::*;

    localparam logic signed [U_W-1:0] PIX_MAX_U = U_W'((1 <<< (PIX_W-1)) - 1);
    localparam logic signed [U_W-1:0] PIX_MIN_U = -(U_W'(1) <<< (PIX_W-1));

    logic [FOC_W-1:0] focal_reg;
    logic [PP_W-1:0]  prin_x_reg, prin_y_reg;
    logic [IMG_W-1:0] img_w_reg, img_h_reg;

    logic     adv;
    logic     stage_v [NUM_W+1];
    ppp_div_t stage_d [NUM_W+1];

    logic     out_valid_reg;
    ppp_out_t out_reg, out_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg  <= FOCAL_RST;
            prin_x_reg <= PRIN_X_RST;
            prin_y_reg <= PRIN_Y_RST;
            img_w_reg  <= '0;
            img_h_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FOCAL:  focal_reg  <= cfg_wdata;
                CFG_PRIN_X: prin_x_reg <= cfg_wdata[PP_W-1:0];
                CFG_PRIN_Y: prin_y_reg <= cfg_wdata[PP_W-1:0];
                CFG_IMG_W:  img_w_reg  <= cfg_wdata[IMG_W-1:0];
                CFG_IMG_H:  img_h_reg  <= cfg_wdata[IMG_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline moves whenever the output register is free or being drained
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    ppp_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .focal     (focal_reg),
        .out_valid (stage_v[0]),
        .out_data  (stage_d[0])
    );

    // divider chain, one quotient bit per stage
    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        ppp_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (stage_v[g]),
            .in_data   (stage_d[g]),
            .out_valid (stage_v[g+1]),
            .out_data  (stage_d[g+1])
        );
    end

    // apply sign, add principal point, bounds test and saturation; behind points give zero
    always_comb begin
        ppp_div_t                d;
        logic [QUO_W-1:0]        qu, qv;
        logic signed [U_W-1:0]   su, sv, u, v, wl, hl;
        logic                    oob;
        d   = stage_d[NUM_W];
        qu  = d.lane_u.nq[QUO_W-1:0];
        qv  = d.lane_v.nq[QUO_W-1:0];
        su  = d.neg_u ? -$signed({2'b00, qu}) : $signed({2'b00, qu});
        sv  = d.neg_v ? -$signed({2'b00, qv}) : $signed({2'b00, qv});
        u   = su + $signed(U_W'(prin_x_reg));
        v   = sv + $signed(U_W'(prin_y_reg));
        wl  = $signed(U_W'({img_w_reg, {PIXEL_FRAC_BITS{1'b0}}}));
        hl  = $signed(U_W'({img_h_reg, {PIXEL_FRAC_BITS{1'b0}}}));
        oob = u[U_W-1] || (u >= wl) || v[U_W-1] || (v >= hl);
        if (d.behind) begin
            out_next.pixel_u     = '0;
            out_next.pixel_v     = '0;
            out_next.proj_status = STAT_BEHIND;
        end else begin
            if (u > PIX_MAX_U) begin
                out_next.pixel_u = PIX_MAX_U[PIX_W-1:0];
            end else if (u < PIX_MIN_U) begin
                out_next.pixel_u = PIX_MIN_U[PIX_W-1:0];
            end else begin
                out_next.pixel_u = u[PIX_W-1:0];
            end
            if (v > PIX_MAX_U) begin
                out_next.pixel_v = PIX_MAX_U[PIX_W-1:0];
            end else if (v < PIX_MIN_U) begin
                out_next.pixel_v = PIX_MIN_U[PIX_W-1:0];
            end else begin
                out_next.pixel_v = v[PIX_W-1:0];
            end
            out_next.proj_status = oob ? STAT_OOB : STAT_SUCCESS;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= stage_v[NUM_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> rtl/ppp_xform.sv
// camera-space transform, depth test and focal scaling, four register stages
// depends on ppp_pkg
module ppp_xform (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  ppp_pkg::ppp_in_t         in_data,
    input  logic [ppp_pkg::FOC_W-1:0] focal,
    output logic                     out_valid,
    output ppp_pkg::ppp_div_t        out_data
);
    import ppp_pkg::*;

    localparam logic signed [CAM_W-1:0] DEPTH_ONE =
        CAM_W'(1) <<< (COORD_FRAC_BITS + ROT_FRAC);

    logic [3:0] valid_reg, valid_next;

    logic signed [DIFF_W-1:0] d_reg [3], d_next [3];
    logic [ROW_W-1:0]         row_reg [3], row_next [3];
    logic signed [PROD_W-1:0] prod_reg [9], prod_next [9];
    logic signed [CAM_W-1:0]  cam_reg [3], cam_next [3];
    ppp_div_t                 div_reg, div_next;

    // valid bits advance with the pipeline
    assign valid_next = {valid_reg[2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    // stage 1: point minus camera position
    always_comb begin
        d_next[0]   = DIFF_W'(in_data.world_x) - DIFF_W'(in_data.cam_pos_x);
        d_next[1]   = DIFF_W'(in_data.world_y) - DIFF_W'(in_data.cam_pos_y);
        d_next[2]   = DIFF_W'(in_data.world_z) - DIFF_W'(in_data.cam_pos_z);
        row_next[0] = in_data.rot_row0;
        row_next[1] = in_data.rot_row1;
        row_next[2] = in_data.rot_row2;
    end

    // stage 2: nine rotation products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[3*i+j] = PROD_W'($signed(row_reg[i][ROT_W*j +: ROT_W]))
                                 * PROD_W'(d_reg[j]);
            end
        end
    end

    // stage 3: row sums
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cam_next[i] = CAM_W'(prod_reg[3*i]) + CAM_W'(prod_reg[3*i+1])
                        + CAM_W'(prod_reg[3*i+2]);
        end
    end

    // stage 4: depth test, floor to coordinate format, scale by focal length
    always_comb begin
        logic signed [CAM_W-1:0] xs_w, ys_w, zs_w;
        logic signed [SCL_W-1:0] xs, ys;
        logic [SCL_W-1:0]        mag_x, mag_y;
        logic [SCL_W+FOC_W-1:0]  num_x, num_y;
        xs_w  = cam_reg[0] >>> ROT_FRAC;
        ys_w  = cam_reg[1] >>> ROT_FRAC;
        zs_w  = cam_reg[2] >>> ROT_FRAC;
        xs    = xs_w[SCL_W-1:0];
        ys    = ys_w[SCL_W-1:0];
        mag_x = xs[SCL_W-1] ? SCL_W'(-xs) : SCL_W'(xs);
        mag_y = ys[SCL_W-1] ? SCL_W'(-ys) : SCL_W'(ys);
        num_x = (SCL_W+FOC_W)'(mag_x) * (SCL_W+FOC_W)'(focal);
        num_y = (SCL_W+FOC_W)'(mag_y) * (SCL_W+FOC_W)'(focal);
        div_next.behind     = !(cam_reg[2] > DEPTH_ONE);
        div_next.neg_u      = xs[SCL_W-1];
        div_next.neg_v      = ys[SCL_W-1];
        div_next.den        = zs_w[DEN_W-1:0];
        div_next.lane_u.rem = '0;
        div_next.lane_u.nq  = num_x[NUM_W-1:0];
        div_next.lane_v.rem = '0;
        div_next.lane_v.nq  = num_y[NUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg    <= d_next;
            row_reg  <= row_next;
            prod_reg <= prod_next;
            cam_reg  <= cam_next;
            div_reg  <= div_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = div_reg;

endmodule

>>> rtl/ppp_div_step.sv
// one registered restoring-division step, one quotient bit for both lanes
// depends on ppp_pkg
module ppp_div_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  ppp_pkg::ppp_div_t in_data,
    output logic              out_valid,
    output ppp_pkg::ppp_div_t out_data
);
    import ppp_pkg::*;

    logic     valid_reg;
    ppp_div_t data_reg, data_next;

    // shift next numerator bit into the remainder, subtract if it fits
    function automatic ppp_lane_t lane_step(ppp_lane_t l, logic [DEN_W-1:0] den);
        logic [REM_W:0] pw, dext, diff;
        logic           ge;
        ppp_lane_t      r;
        pw    = {l.rem, l.nq[NUM_W-1]};
        dext  = {{(REM_W+1-DEN_W){1'b0}}, den};
        ge    = pw >= dext;
        diff  = pw - dext;
        r.rem = ge ? diff[REM_W-1:0] : pw[REM_W-1:0];
        r.nq  = {l.nq[NUM_W-2:0], ge};
        return r;
    endfunction

    always_comb begin
        data_next        = in_data;
        data_next.lane_u = lane_step(in_data.lane_u, in_data.den);
        data_next.lane_v = lane_step(in_data.lane_v, in_data.den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/ppp_checker.sv
// port-level checks for pinhole_point_projection, bound to the top level
// depends on ppp_pkg
module ppp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input ppp_pkg::ppp_in_t               s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input ppp_pkg::ppp_out_t              m_data,
    input logic                           cfg_we,
    input logic [ppp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [ppp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ppp_pkg::*;

    // a point behind the camera reports pixel zero
    a_behind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.proj_status == STAT_BEHIND |->
            m_data.pixel_u == '0 && m_data.pixel_v == '0)
        else $error("behind result with nonzero pixel");

    // status is one of the three codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.proj_status == STAT_SUCCESS
                 || m_data.proj_status == STAT_BEHIND
                 || m_data.proj_status == STAT_OOB)
        else $error("illegal status code");

    // input side stalls only while a result waits
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready not tied to output stall");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind pinhole_point_projection ppp_checker u_ppp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
);

>>> test/tb_top.sv
// testbench for pinhole_point_projection: directed and random projections,
// register sweeps, backpressure and drain; depends on ppp_pkg and the block rtl
`timescale 1ns / 100ps

module tb_top;
    import ppp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int LONG_HOLD      = 300;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    ppp_in_t           s_data;
    logic              m_valid;
    logic              m_ready;
    ppp_out_t          m_data;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // shadow copy of the camera registers
    longint focal_q, prin_x_q, prin_y_q, img_w_q, img_h_q;

    ppp_out_t pixel_queue[$];
    int       error_count;
    int       idle_count;
    int       rx_hold;
    bit       tx_bursty;
    bit       rx_bursty;

    pinhole_point_projection DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // expected pixel and status for one point under the current registers
    function automatic ppp_out_t project_point(ppp_in_t p);
        logic [ROW_W-1:0] rows [3];
        longint diff [3];
        longint cam [3];
        longint xs, ys, zs, u, v;
        ppp_out_t r;
        rows[0] = p.rot_row0;
        rows[1] = p.rot_row1;
        rows[2] = p.rot_row2;
        diff[0] = longint'(p.world_x) - longint'(p.cam_pos_x);
        diff[1] = longint'(p.world_y) - longint'(p.cam_pos_y);
        diff[2] = longint'(p.world_z) - longint'(p.cam_pos_z);
        for (int i = 0; i < 3; i++) begin
            cam[i] = 0;
            for (int j = 0; j < 3; j++)
                cam[i] += longint'($signed(rows[i][ROT_W*j +: ROT_W])) * diff[j];
        end
        if (cam[2] <= (64'sd1 <<< (COORD_FRAC_BITS + ROT_FRAC))) begin
            r.pixel_u = '0;
            r.pixel_v = '0;
            r.proj_status = STAT_BEHIND;
            return r;
        end
        xs = cam[0] >>> ROT_FRAC;
        ys = cam[1] >>> ROT_FRAC;
        zs = cam[2] >>> ROT_FRAC;
        u = (xs * focal_q) / zs + prin_x_q;
        v = (ys * focal_q) / zs + prin_y_q;
        if (u < 0 || u >= (img_w_q << PIXEL_FRAC_BITS) ||
            v < 0 || v >= (img_h_q << PIXEL_FRAC_BITS))
            r.proj_status = STAT_OOB;
        else
            r.proj_status = STAT_SUCCESS;
        r.pixel_u = (u > 8388607) ? 24'sd8388607 : (u < -8388608) ? -24'sd8388608 : u[23:0];
        r.pixel_v = (v > 8388607) ? 24'sd8388607 : (v < -8388608) ? -24'sd8388608 : v[23:0];
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] rot_row(int a, int b, int c);
        return {ROT_W'(c), ROT_W'(b), ROT_W'(a)};
    endfunction

    function automatic ppp_in_t axis_point(longint x, longint y, longint z);
        ppp_in_t p;
        p = '0;
        p.rot_row0 = rot_row(16384, 0, 0);
        p.rot_row1 = rot_row(0, 16384, 0);
        p.rot_row2 = rot_row(0, 0, 16384);
        p.world_x = x[31:0];
        p.world_y = y[31:0];
        p.world_z = z[31:0];
        return p;
    endfunction

    // mostly plausible poses with points ahead, some raw bit noise
    function automatic ppp_in_t random_point();
        ppp_in_t p;
        int e [9];
        logic [12*32-1:0] noise;
        if ($urandom_range(0, 9) == 0) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            p = noise[$bits(ppp_in_t)-1:0];
            return p;
        end
        for (int k = 0; k < 9; k++)
            e[k] = (k % 4 == 0) ? 16384 - int'($urandom_range(0, 3000))
                                : int'($urandom_range(0, 6000)) - 3000;
        if ($urandom_range(0, 19) == 0)
            e[$urandom_range(0, 8)] = ($urandom_range(0, 1)) ? -32768 : 32767;
        p.rot_row0 = rot_row(e[0], e[1], e[2]);
        p.rot_row1 = rot_row(e[3], e[4], e[5]);
        p.rot_row2 = rot_row(e[6], e[7], e[8]);
        p.cam_pos_x = $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
        p.cam_pos_y = $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
        p.cam_pos_z = $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
        p.world_x = p.cam_pos_x + $urandom_range(0, 32'h00c8_0000) - 32'h0064_0000;
        p.world_y = p.cam_pos_y + $urandom_range(0, 32'h00c8_0000) - 32'h0064_0000;
        p.world_z = p.cam_pos_z + $urandom_range(0, 32'h00c8_0000) - 32'h0010_0000;
        return p;
    endfunction

    // one input transaction, expectation queued on acceptance
    task automatic send_point(ppp_in_t p);
        int gap;
        gap = 0;
        if (tx_bursty && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        pixel_queue.insert(pixel_queue.size(), project_point(p));
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pixel_queue.size() == 0);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_FOCAL:  focal_q  = val & 64'hff_ffff;
            CFG_PRIN_X: prin_x_q = val & 64'hf_ffff;
            CFG_PRIN_Y: prin_y_q = val & 64'hf_ffff;
            CFG_IMG_W:  img_w_q  = val & 64'hfff;
            CFG_IMG_H:  img_h_q  = val & 64'hfff;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_camera(longint f, longint px, longint py, longint w, longint h);
        wait_idle();
        write_reg(CFG_FOCAL, f);
        write_reg(CFG_PRIN_X, px);
        write_reg(CFG_PRIN_Y, py);
        write_reg(CFG_IMG_W, w);
        write_reg(CFG_IMG_H, h);
    endtask

    task automatic send_random(int n);
        for (int k = 0; k < n; k++) send_point(random_point());
    endtask

    // reset values: zero image size, so every point in front is out of bounds
    task automatic test_reset_defaults();
        send_point(axis_point(0, 0, 32'h0010_0000));
        send_point(axis_point(32'h0001_0000, -32'h0001_0000, 32'h0004_0000));
    endtask

    // depth threshold, saturation, bounds edges, field extremes
    task automatic test_directed();
        ppp_in_t p;
        set_camera(256, 0, 0, 4, 4);
        send_point(axis_point(0, 0, 32'h0001_0000));       // depth exactly one
        send_point(axis_point(0, 0, 32'h0001_0001));       // just past one
        send_point(axis_point(0, 0, -32'h0010_0000));      // negative depth
        send_point(axis_point(0, 0, 32'h0002_0000));       // pixel at the origin
        send_point(axis_point(32'h0005_fffe, 0, 32'h0002_0000)); // inside the image
        send_point(axis_point(32'h0008_0000, 0, 32'h0002_0000)); // right edge, out
        send_point(axis_point(0, 32'h0008_0000, 32'h0002_0000)); // bottom edge, out
        send_point(axis_point(-32'h0000_0200, 0, 32'h0002_0000)); // just left
        send_point(axis_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_8000));
        p = axis_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        p.cam_pos_x = 32'h8000_0000;
        p.cam_pos_y = 32'h8000_0000;
        p.cam_pos_z = 32'h8000_0000;
        send_point(p);
        p.rot_row0 = rot_row(-32768, -32768, -32768);
        p.rot_row1 = rot_row(32767, 32767, 32767);
        p.rot_row2 = rot_row(32767, -32768, 32767);
        send_point(p);
        p.rot_row2 = rot_row(-32768, -32768, -32768);
        send_point(p);
        p = '1;
        send_point(p);
        p = '0;
        send_point(p);
        set_camera(24'hff_ffff, 20'hf_ffff, 20'hf_ffff, 12'hfff, 12'hfff);
        send_point(axis_point(32'h0100_0000, -32'h0100_0000, 32'h0001_0100));
        send_point(axis_point(32'h0000_1000, 32'h0000_1000, 32'h0100_0000));
        set_camera(0, 0, 0, 1, 1);
        send_point(axis_point(32'h1234_5678, -32'h1234_5678, 32'h0003_0000));
        // unknown register indexes are ignored
        wait_idle();
        write_reg(3'd5, 24'hff_ffff);
        write_reg(3'd6, 24'hff_ffff);
        write_reg(3'd7, 24'hff_ffff);
        send_point(axis_point(0, 0, 32'h0003_0000));
    endtask

    // random points across several camera settings
    task automatic test_camera_sweep();
        set_camera(128000, 81920, 61440, 640, 480);
        send_random(300);
        set_camera(24'hff_ffff, 20'hf_ffff, 0, 12'hfff, 12'hfff);
        send_random(200);
        set_camera(0, 0, 20'hf_ffff, 0, 12'hfff);
        send_random(150);
        set_camera(1000 << 8, 160 << 8, 120 << 8, 320, 240);
        send_random(300);
        set_camera($urandom_range(0, 24'hff_ffff), $urandom_range(0, 20'hf_ffff),
                   $urandom_range(0, 20'hf_ffff), $urandom_range(0, 4095),
                   $urandom_range(0, 4095));
        send_random(150);
    endtask

    // result side held off long enough to fill the pipeline
    task automatic test_backpressure();
        set_camera(500 << 8, 320 << 8, 240 << 8, 640, 480);
        tx_bursty = 1'b0;
        rx_hold   = LONG_HOLD;
        send_random(150);
        tx_bursty = 1'b1;
    endtask

    // sender pauses until the pipeline has drained, then resumes
    task automatic test_drain_pause();
        send_random(40);
        wait_idle();
        rx_bursty = 1'b0;
        tx_bursty = 1'b0;
        send_random(60);
        rx_bursty = 1'b1;
        tx_bursty = 1'b1;
    endtask

    // result side ready with random short and long stalls
    initial begin
        int gap;
        gap = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else if (gap > 0) begin
                m_ready <= 1'b0;
                gap--;
            end else begin
                m_ready <= 1'b1;
                if (rx_bursty && $urandom_range(0, 4) == 0)
                    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        ppp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_queue.size() == 0) begin
                $error("unexpected result transaction %h", m_data);
                error_count++;
            end else begin
                want = pixel_queue.pop_front();
                if (m_data.pixel_u !== want.pixel_u) begin
                    $error("pixel_u expected %0d actual %0d", want.pixel_u, m_data.pixel_u);
                    error_count++;
                end
                if (m_data.pixel_v !== want.pixel_v) begin
                    $error("pixel_v expected %0d actual %0d", want.pixel_v, m_data.pixel_v);
                    error_count++;
                end
                if (m_data.proj_status !== want.proj_status) begin
                    $error("proj_status expected %0d actual %0d",
                           want.proj_status, m_data.proj_status);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        idle_count  = 0;
        rx_hold     = 0;
        tx_bursty   = 1'b1;
        rx_bursty   = 1'b1;
        focal_q  = 128000;
        prin_x_q = 81920;
        prin_y_q = 61440;
        img_w_q  = 0;
        img_h_q  = 0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_directed();
        test_camera_sweep();
        test_backpressure();
        test_drain_pause();

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pixel_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
rtl/ppp_pkg.sv
rtl/ppp_xform.sv
rtl/ppp_div_step.sv
rtl/pinhole_point_projection.sv
rtl/ppp_checker.sv
test/tb_top.sv
